### rtl/phdf_pkg.sv
// Shared constants, types and helper functions of the packet header dedup filter.
package phdf_pkg;

	localparam int HIST_DEPTH = 10;
	localparam int HIST_IDX_W = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
	localparam int HIST_CNT_W = $clog2(HIST_DEPTH + 1);

	localparam int BYTE_W = 8;
	localparam int ADDR_W = 10;
	localparam int ID_W   = 7;
	localparam int LEN_W  = 8;

	localparam logic [LEN_W-1:0] HEADER_BYTES = LEN_W'(11);
	localparam logic [LEN_W-1:0] POS_SEP1     = LEN_W'(3);
	localparam logic [LEN_W-1:0] POS_SEP2     = LEN_W'(7);
	localparam logic [LEN_W-1:0] POS_BAR      = LEN_W'(10);
	localparam logic [LEN_W-1:0] ACK_LEN      = LEN_W'(3);
	localparam logic [LEN_W-1:0] LEN_MAX      = {LEN_W{1'b1}};

	localparam logic [BYTE_W-1:0] CH_DASH = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_BAR  = 8'h7C;
	localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE = 8'h39;
	localparam logic [BYTE_W-1:0] CH_A    = 8'h41;
	localparam logic [BYTE_W-1:0] CH_C    = 8'h43;
	localparam logic [BYTE_W-1:0] CH_K    = 8'h4B;

	// Character expected at a given offset of the three-byte acknowledgment text.
	function automatic logic [BYTE_W-1:0] ack_char(input logic [1:0] idx);
		logic [BYTE_W-1:0] ch;
		unique case (idx)
			2'd0:    ch = CH_A;
			2'd1:    ch = CH_C;
			2'd2:    ch = CH_K;
			default: ch = '0;
		endcase
		return ch;
	endfunction

	// Packet summary as it stands once the final byte has been folded in.
	typedef struct packed {
		logic              hdr;
		logic [ADDR_W-1:0] org;
		logic [ADDR_W-1:0] dst;
		logic [ID_W-1:0]   pid;
		logic [LEN_W-1:0]  plen;
		logic              ack_text;
	} pkt_sum_t;

	typedef struct packed {
		logic              fire;
		logic              want_record;
		logic [ADDR_W-1:0] org;
		logic [ID_W-1:0]   pid;
	} hist_req_t;

	typedef struct packed {
		logic              accepted;
		logic              has_header;
		logic [ADDR_W-1:0] origin_address;
		logic [ADDR_W-1:0] destination_address;
		logic [ID_W-1:0]   packet_number;
		logic              duplicate;
		logic              is_ack;
		logic              send_ack;
		logic [LEN_W-1:0]  payload_length;
	} result_t;

endpackage

### rtl/phdf_parse.sv
// Byte-by-byte header parser: digit groups, separators, ACK match and lengths.
module phdf_parse (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [phdf_pkg::BYTE_W-1:0]  byte_s1,
	input  logic                         eop_s1,
	input  logic                         advance,
	output phdf_pkg::pkt_sum_t           sum
);
	import phdf_pkg::*;

	logic [LEN_W-1:0]  pos_q, pos_n;
	logic [LEN_W-1:0]  pcnt_q, pcnt_n;
	logic [ADDR_W-1:0] org_q, org_n;
	logic [ADDR_W-1:0] dst_q, dst_n;
	logic [ID_W-1:0]   pid_q, pid_n;
	logic [2:0]        stop_q, stop_n;
	logic              sep_q, sep_n;
	logic [1:0]        ack_q, ack_n;

	logic              is_digit;
	logic [3:0]        dval;
	logic [13:0]       org_mac, dst_mac, pid_mac;

	always_comb begin
		is_digit = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
		dval     = 4'(byte_s1 - CH_ZERO);
		org_mac  = 14'(org_q) * 14'd10 + 14'(dval);
		dst_mac  = 14'(dst_q) * 14'd10 + 14'(dval);
		pid_mac  = 14'(pid_q) * 14'd10 + 14'(dval);

		pos_n  = pos_q;
		pcnt_n = pcnt_q;
		org_n  = org_q;
		dst_n  = dst_q;
		pid_n  = pid_q;
		stop_n = stop_q;
		sep_n  = sep_q;
		ack_n  = ack_q;

		// A digit group ends for good at its first non-digit.
		priority if (pos_q < POS_SEP1) begin
			if (!stop_q[0]) begin
				if (is_digit) org_n = ADDR_W'(org_mac);
				else          stop_n[0] = 1'b1;
			end
		end else if (pos_q == POS_SEP1 || pos_q == POS_SEP2) begin
			sep_n = sep_q && (byte_s1 == CH_DASH);
		end else if (pos_q < POS_SEP2) begin
			if (!stop_q[1]) begin
				if (is_digit) dst_n = ADDR_W'(dst_mac);
				else          stop_n[1] = 1'b1;
			end
		end else if (pos_q < POS_BAR) begin
			if (!stop_q[2]) begin
				if (is_digit) pid_n = ID_W'(pid_mac);
				else          stop_n[2] = 1'b1;
			end
		end else if (pos_q == POS_BAR) begin
			sep_n = sep_q && (byte_s1 == CH_BAR);
		end else begin
		end

		if (pos_q < ACK_LEN && byte_s1 != ack_char(pos_q[1:0])) ack_n[0] = 1'b0;
		if (pos_q >= HEADER_BYTES) begin
			if (pcnt_q < ACK_LEN && byte_s1 != ack_char(pcnt_q[1:0])) ack_n[1] = 1'b0;
			if (pcnt_q != LEN_MAX) pcnt_n = pcnt_q + 1'b1;
		end
		if (pos_q != LEN_MAX) pos_n = pos_q + 1'b1;

		sum.hdr      = (pos_n >= HEADER_BYTES) && sep_n;
		sum.org      = sum.hdr ? org_n : '0;
		sum.dst      = sum.hdr ? dst_n : '0;
		sum.pid      = sum.hdr ? pid_n : '0;
		sum.plen     = sum.hdr ? pcnt_n : pos_n;
		sum.ack_text = sum.hdr ? (ack_n[1] && pcnt_n == ACK_LEN)
		                       : (ack_n[0] && pos_n == ACK_LEN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			pcnt_q <= '0;
			org_q  <= '0;
			dst_q  <= '0;
			pid_q  <= '0;
			stop_q <= '0;
			sep_q  <= 1'b1;
			ack_q  <= 2'b11;
		end else if (advance) begin
			if (eop_s1) begin
				pos_q  <= '0;
				pcnt_q <= '0;
				org_q  <= '0;
				dst_q  <= '0;
				pid_q  <= '0;
				stop_q <= '0;
				sep_q  <= 1'b1;
				ack_q  <= 2'b11;
			end else begin
				pos_q  <= pos_n;
				pcnt_q <= pcnt_n;
				org_q  <= org_n;
				dst_q  <= dst_n;
				pid_q  <= pid_n;
				stop_q <= stop_n;
				sep_q  <= sep_n;
				ack_q  <= ack_n;
			end
		end
	end

endmodule

### rtl/phdf_history.sv
// Ring of recent (origin, id) pairs with parallel lookup and conditional record.
module phdf_history (
	input  logic                clk,
	input  logic                arst_n,
	input  phdf_pkg::hist_req_t req,
	output logic                hit
);
	import phdf_pkg::*;

	logic [ADDR_W-1:0]     org_q [HIST_DEPTH];
	logic [ID_W-1:0]       pid_q [HIST_DEPTH];
	logic [HIST_IDX_W-1:0] wr_q;
	logic [HIST_CNT_W-1:0] cnt_q;
	logic                  record;

	// Entries at or beyond the fill count have never been written.
	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < HIST_DEPTH; i++) begin
			if (HIST_CNT_W'(i) < cnt_q && org_q[i] == req.org && pid_q[i] == req.pid)
				hit = 1'b1;
		end
		record = req.fire && req.want_record && !hit;
	end

	always_ff @(posedge clk) begin
		if (record) begin
			org_q[wr_q] <= req.org;
			pid_q[wr_q] <= req.pid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			cnt_q <= '0;
		end else if (record) begin
			wr_q <= (wr_q == HIST_IDX_W'(HIST_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (cnt_q != HIST_CNT_W'(HIST_DEPTH)) cnt_q <= cnt_q + 1'b1;
		end
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= HIST_CNT_W'(HIST_DEPTH))
		else $error("history fill count beyond depth");
	a_wr_follows_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != HIST_CNT_W'(HIST_DEPTH) |-> HIST_CNT_W'(wr_q) == cnt_q)
		else $error("write index out of step with fill count before wrap");
	a_record_grows: assert property (@(posedge clk) disable iff (!arst_n)
		record && cnt_q != HIST_CNT_W'(HIST_DEPTH) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("recorded pair did not extend history");
`endif

endmodule

### rtl/packet_header_dedup_filter.sv
// Top level of the packet header dedup filter: input stage, decision logic, result register.
// Usage:
//   Packet bytes enter on the input channel (in_valid/in_ready, rx_byte,
//   end_of_packet), one transaction per byte; end_of_packet marks the last
//   byte. One status transaction leaves on the output channel
//   (out_valid/out_ready) for every packet, and none for other bytes.
//   The node address is written on the cfg channel (cfg_valid/cfg_ready,
//   cfg_data), which is always ready; write it only while the block is idle.
//   Throughput is one byte per cycle, packets back to back included, as long
//   as the output is not stalled. A byte is registered on acceptance and
//   folded into the parse state when it leaves the input stage; for a final
//   byte the status is registered at that same edge and out_valid rises with
//   it. Duplicate lookup compares all ring entries in parallel in the same
//   cycle as the final byte is folded in.
//   When the receiver stalls, the status holds in the result register and
//   bytes keep flowing until a second final byte reaches the input stage,
//   which then waits and drops in_ready.
//   Reset clears the parse state, the history ring fill count and the node
//   address; no clearing pass is needed.
module packet_header_dedup_filter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [phdf_pkg::BYTE_W-1:0]  rx_byte,
	input  logic                         end_of_packet,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         accepted,
	output logic                         has_header,
	output logic [phdf_pkg::ADDR_W-1:0]  origin_address,
	output logic [phdf_pkg::ADDR_W-1:0]  destination_address,
	output logic [phdf_pkg::ID_W-1:0]    packet_number,
	output logic                         duplicate,
	output logic                         is_ack,
	output logic                         send_ack,
	output logic [phdf_pkg::LEN_W-1:0]   payload_length,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [phdf_pkg::ADDR_W-1:0]  cfg_data
);
	import phdf_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              eop_s1;
	logic              out_free;
	logic              advance;
	logic              fire;
	logic [ADDR_W-1:0] node_q;
	pkt_sum_t          sum;
	hist_req_t         req;
	logic              hit;
	result_t           res;
	result_t           res_q;
	logic              out_valid_q;

	assign out_free  = !out_valid_q || out_ready;
	assign advance   = valid_s1 && (!eop_s1 || out_free);
	assign in_ready  = !valid_s1 || advance;
	assign fire      = advance && eop_s1;
	assign cfg_ready = 1'b1;

	phdf_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_s1 (byte_s1),
		.eop_s1  (eop_s1),
		.advance (advance),
		.sum     (sum)
	);

	always_comb begin
		res.has_header          = sum.hdr;
		res.origin_address      = sum.org;
		res.destination_address = sum.dst;
		res.packet_number       = sum.pid;
		res.payload_length      = sum.plen;
		res.accepted            = (sum.dst == '0) || (sum.dst == node_q);
		res.duplicate           = res.accepted && sum.hdr && hit;
		res.is_ack              = res.accepted && sum.ack_text;
		res.send_ack            = res.accepted && (sum.dst != '0) && !res.is_ack;

		req.fire        = fire;
		req.want_record = res.send_ack && sum.hdr;
		req.org         = sum.org;
		req.pid         = sum.pid;
	end

	phdf_history u_history (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.hit    (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			node_q      <= '0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (fire) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (cfg_valid) node_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
			eop_s1  <= end_of_packet;
		end
		if (fire) res_q <= res;
	end

	assign out_valid           = out_valid_q;
	assign accepted            = res_q.accepted;
	assign has_header          = res_q.has_header;
	assign origin_address      = res_q.origin_address;
	assign destination_address = res_q.destination_address;
	assign packet_number       = res_q.packet_number;
	assign duplicate           = res_q.duplicate;
	assign is_ack              = res_q.is_ack;
	assign send_ack            = res_q.send_ack;
	assign payload_length      = res_q.payload_length;

`ifndef SYNTH
	a_dup_needs_header: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !res_q.duplicate || (res_q.has_header && res_q.accepted))
		else $error("duplicate flagged without an accepted header");
	a_ack_send_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.is_ack && res_q.send_ack))
		else $error("acknowledgment owed for an ACK packet");
	a_no_header_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.has_header |->
			res_q.origin_address == '0 && res_q.destination_address == '0 &&
			res_q.packet_number == '0 && res_q.accepted)
		else $error("header fields set on a packet without header");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && eop_s1 && out_valid_q && !out_ready |=> valid_s1 && $stable(byte_s1))
		else $error("final byte left the input stage while the result was stalled");
`endif

endmodule
